// ===== rtl/sample_variance_threshold_filter_top_macros.svh =====
// assertion macros shared by the variance filter modules
// define NO_ASSERTIONS to compile them out
`ifndef SAMPLE_VARIANCE_THRESHOLD_FILTER_TOP_MACROS_SVH
`define SAMPLE_VARIANCE_THRESHOLD_FILTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define SVTF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");
// consequence that must hold in the cycle after the antecedent
`define SVTF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define SVTF_ASSERT(lbl, prop)
`define SVTF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/svtf_pkg.sv =====
`timescale 1ns / 1ps
package svtf_pkg;

	// group size bound and field widths
	localparam int MAX_SAMPLES = 65536;
	localparam int Z_W         = 24;
	localparam int CNT_W       = 17;
	localparam int SUM_W       = 40;
	localparam int SQS_W       = 63;
	localparam int SQ_W        = 2 * Z_W;
	localparam int THR_W       = 40;

	// shared multiplier and verdict accumulators
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 80;
	localparam int HI_W   = SUM_W - MUL_W;

	// group queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam logic REG_FILTER_ENABLE = 1'b0;
	localparam logic REG_MAX_VARIANCE  = 1'b1;

	// input beat
	typedef struct packed {
		logic signed [Z_W-1:0] z_sample;
		logic                  last_sample;
	} svtf_in_t;

	// result beat
	typedef struct packed {
		logic keep_group;
		logic count_overflow;
	} svtf_out_t;

	// totals of one finished group, front to back
	typedef struct packed {
		logic [CNT_W-1:0] sample_count;
		logic [SUM_W-1:0] height_sum;
		logic [SQS_W-1:0] height_square_sum;
		logic             overflow_seen;
	} svtf_rec_t;

	// back end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_LAST,
		BK_DONE
	} svtf_bk_state_t;

	// partial products, in issue order
	typedef enum logic [2:0] {
		STEP_NN1,
		STEP_NS2L,
		STEP_NS2H,
		STEP_MLML,
		STEP_MHML,
		STEP_MHMH,
		STEP_TLP,
		STEP_THP
	} svtf_step_t;

endpackage

// ===== rtl/sample_variance_threshold_filter_top.sv =====
`timescale 1ns / 1ps
// Height variance filter. Samples of a group stream in one beat per cycle, stalled
// while a final beat finds the queue full, and are accumulated (count, sum, sum of
// squares) in the front end; the beat marked last hands the group totals to a
// two-entry queue. The back end decides each group exactly in integers
// (n*S2 - S1^2 < max_variance*n*(n-1)) by running eight 32x32 partial products
// through one shared multiplier, then one compare, and registers the verdict.
// Input throughput is one sample per cycle as long as groups average at least
// 11 samples; shorter groups are limited by the back end multiplier.
// A group with more than 65536 samples is dropped with count_overflow set.
// Registers: filter_enable at byte 0x0, max_variance (40 bits) at byte 0x8.
module sample_variance_threshold_filter_top
	import svtf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  svtf_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output svtf_out_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic             filter_enable_q;
	logic [THR_W-1:0] max_variance_q;
	logic             cfg_wr;

	logic      fr_valid;
	logic      fr_ready;
	svtf_rec_t fr_rec;
	logic      bk_valid;
	logic      bk_ready;
	svtf_rec_t bk_rec;

	// register port, one register per 8 bytes
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			max_variance_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_FILTER_ENABLE: filter_enable_q <= pwdata[0];
				REG_MAX_VARIANCE:  max_variance_q  <= pwdata[THR_W-1:0];
				default:           filter_enable_q <= filter_enable_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_FILTER_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, filter_enable_q};
			REG_MAX_VARIANCE:  prdata = {{(APB_DATA_W-THR_W){1'b0}}, max_variance_q};
			default:           prdata = '0;
		endcase
	end

	// accumulation front end
	svtf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.rec_valid (fr_valid),
		.rec_ready (fr_ready),
		.rec       (fr_rec)
	);

	// group totals waiting for a verdict
	svtf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_rec   (fr_rec),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_rec    (bk_rec)
	);

	// verdict back end
	svtf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (bk_valid),
		.rec_ready     (bk_ready),
		.rec           (bk_rec),
		.filter_enable (filter_enable_q),
		.max_variance  (max_variance_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

// ===== rtl/svtf_queue.sv =====
`timescale 1ns / 1ps
module svtf_queue
	import svtf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  svtf_rec_t push_rec,
	output logic      pop_valid,
	input  logic      pop_ready,
	output svtf_rec_t pop_rec
);

	svtf_rec_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_rec    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ===== rtl/svtf_front.sv =====
`timescale 1ns / 1ps
`include "sample_variance_threshold_filter_top_macros.svh"
module svtf_front
	import svtf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  svtf_in_t  in_data,
	output logic      rec_valid,
	input  logic      rec_ready,
	output svtf_rec_t rec
);

	logic                  valid_s1;
	logic signed [Z_W-1:0] z_s1;
	logic                  last_s1;
	logic [SQ_W-1:0]       sq_s1;

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQS_W-1:0] sqsum_q;
	logic             ovf_q;

	logic [Z_W-1:0]   z_mag;
	logic             full;
	logic             advance;
	logic             push;
	logic [CNT_W-1:0] count_nx;
	logic [SUM_W-1:0] sum_nx;
	logic [SQS_W-1:0] sqsum_nx;
	logic             ovf_nx;

	// magnitude of the incoming height, fits unsigned in the field width
	assign z_mag = in_data.z_sample[Z_W-1] ? (~in_data.z_sample + 1'b1) : in_data.z_sample;

	// stage 1 holds one beat; it drains unless a final beat finds the queue full
	assign advance  = !valid_s1 || !last_s1 || rec_ready;
	assign in_ready = advance;
	assign push     = valid_s1 && last_s1 && rec_ready;

	// square of the height, registered before accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			z_s1    <= in_data.z_sample;
			last_s1 <= in_data.last_sample;
			sq_s1   <= SQ_W'(z_mag) * SQ_W'(z_mag);
		end
	end

	// running totals with this beat folded in
	always_comb begin
		full     = (count_q == CNT_W'(MAX_SAMPLES));
		count_nx = count_q;
		sum_nx   = sum_q;
		sqsum_nx = sqsum_q;
		ovf_nx   = ovf_q;
		if (full) begin
			ovf_nx = 1'b1;
		end else begin
			count_nx = count_q + 1'b1;
			sum_nx   = sum_q + {{(SUM_W-Z_W){z_s1[Z_W-1]}}, z_s1};
			sqsum_nx = sqsum_q + {{(SQS_W-SQ_W){1'b0}}, sq_s1};
		end
	end

	assign rec_valid             = valid_s1 && last_s1;
	assign rec.sample_count      = count_nx;
	assign rec.height_sum        = sum_nx;
	assign rec.height_square_sum = sqsum_nx;
	assign rec.overflow_seen     = ovf_nx;

	// accumulators, cleared once a group is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			ovf_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				count_q <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_nx;
				sum_q   <= sum_nx;
				sqsum_q <= sqsum_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	`SVTF_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_SAMPLES))
	`SVTF_ASSERT_NEXT(a_group_clear, push, count_q == '0 && !ovf_q && sum_q == '0)

endmodule

// ===== rtl/svtf_back.sv =====
`timescale 1ns / 1ps
`include "sample_variance_threshold_filter_top_macros.svh"
module svtf_back
	import svtf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_valid,
	output logic             rec_ready,
	input  svtf_rec_t        rec,
	input  logic             filter_enable,
	input  logic [THR_W-1:0] max_variance,
	output logic             out_valid,
	input  logic             out_ready,
	output svtf_out_t        out_data
);

	svtf_bk_state_t state_q;
	svtf_bk_state_t state_d;
	svtf_step_t     step_q;
	svtf_step_t     tag_s1;
	logic           prod_vld_s1;
	logic [PROD_W-1:0] prod_s1;

	logic [CNT_W-1:0] n_q;
	logic [SQS_W-1:0] s2_q;
	logic [SUM_W-1:0] mag_q;
	logic             ovf_q;
	logic [MUL_W-1:0] p_q;
	logic [ACC_W-1:0] lhs_q;
	logic [ACC_W-1:0] rhs_q;

	logic             out_valid_q;
	svtf_out_t        out_q;

	logic              pop;
	logic              issue;
	logic              load_out;
	logic [MUL_W-1:0]  op_a;
	logic [MUL_W-1:0]  op_b;
	logic [PROD_W-1:0] mul;
	logic [ACC_W-1:0]  prod_ext;
	svtf_out_t         verdict;

	// sequencer: take a group, run eight partial products, compare, hand out
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (rec_valid) begin
					pop     = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				issue = 1'b1;
				if (step_q == STEP_THP) begin
					state_d = BK_LAST;
				end
			end
			BK_LAST: begin
				state_d = BK_DONE;
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign rec_ready = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			prod_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			prod_vld_s1 <= issue;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			STEP_NN1: begin
				op_a = {{(MUL_W-CNT_W){1'b0}}, n_q};
				op_b = {{(MUL_W-CNT_W){1'b0}}, n_q - 1'b1};
			end
			STEP_NS2L: begin
				op_a = {{(MUL_W-CNT_W){1'b0}}, n_q};
				op_b = s2_q[MUL_W-1:0];
			end
			STEP_NS2H: begin
				op_a = {{(MUL_W-CNT_W){1'b0}}, n_q};
				op_b = {{(2*MUL_W-SQS_W){1'b0}}, s2_q[SQS_W-1:MUL_W]};
			end
			STEP_MLML: begin
				op_a = mag_q[MUL_W-1:0];
				op_b = mag_q[MUL_W-1:0];
			end
			STEP_MHML: begin
				op_a = {{(MUL_W-HI_W){1'b0}}, mag_q[SUM_W-1:MUL_W]};
				op_b = mag_q[MUL_W-1:0];
			end
			STEP_MHMH: begin
				op_a = {{(MUL_W-HI_W){1'b0}}, mag_q[SUM_W-1:MUL_W]};
				op_b = {{(MUL_W-HI_W){1'b0}}, mag_q[SUM_W-1:MUL_W]};
			end
			STEP_TLP: begin
				op_a = max_variance[MUL_W-1:0];
				op_b = p_q;
			end
			STEP_THP: begin
				op_a = {{(MUL_W-(THR_W-MUL_W)){1'b0}}, max_variance[THR_W-1:MUL_W]};
				op_b = p_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul      = PROD_W'(op_a) * PROD_W'(op_b);
	assign prod_ext = {{(ACC_W-PROD_W){1'b0}}, prod_s1};

	// group load, product register and accumulation
	always_ff @(posedge clk) begin
		if (pop) begin
			n_q    <= rec.sample_count;
			s2_q   <= rec.height_square_sum;
			ovf_q  <= rec.overflow_seen;
			mag_q  <= rec.height_sum[SUM_W-1] ? (~rec.height_sum + 1'b1) : rec.height_sum;
			lhs_q  <= '0;
			rhs_q  <= '0;
			step_q <= STEP_NN1;
		end else begin
			if (issue) begin
				step_q <= svtf_step_t'(step_q + 1'b1);
			end
			if (prod_vld_s1) begin
				case (tag_s1)
					STEP_NN1:  p_q   <= prod_s1[MUL_W-1:0];
					STEP_NS2L: lhs_q <= lhs_q + prod_ext;
					STEP_NS2H: lhs_q <= lhs_q + (prod_ext << MUL_W);
					STEP_MLML: lhs_q <= lhs_q - prod_ext;
					STEP_MHML: lhs_q <= lhs_q - (prod_ext << (MUL_W + 1));
					STEP_MHMH: lhs_q <= lhs_q - (prod_ext << (2 * MUL_W));
					STEP_TLP:  rhs_q <= rhs_q + prod_ext;
					STEP_THP:  rhs_q <= rhs_q + (prod_ext << MUL_W);
					default:   lhs_q <= lhs_q;
				endcase
			end
		end
		if (issue) begin
			prod_s1 <= mul;
			tag_s1  <= step_q;
		end
		if (load_out) begin
			out_q <= verdict;
		end
	end

	// n*S2 - S1^2 against thr*n*(n-1); overflow always drops
	always_comb begin
		verdict.count_overflow = ovf_q;
		verdict.keep_group     = !ovf_q &&
			(!filter_enable || (n_q <= CNT_W'(1)) || (lhs_q < rhs_q));
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SVTF_ASSERT(a_prod_busy, !prod_vld_s1 || state_q == BK_MUL || state_q == BK_LAST)
	`SVTF_ASSERT_NEXT(a_pop_runs, pop, state_q == BK_MUL && step_q == STEP_NN1)

endmodule

// ===== test/sample_variance_threshold_filter_top_test.sv =====
`timescale 1ns / 1ps
module sample_variance_threshold_filter_top_test;
	import svtf_pkg::*;

	// register addresses, one 64-bit slot per register
	localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE = {REG_FILTER_ENABLE, 3'b000};
	localparam logic [APB_ADDR_W-1:0] ADDR_LIMIT  = {REG_MAX_VARIANCE, 3'b000};

	localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
	localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};
	localparam int Z_HI = 2 ** (Z_W - 1) - 1;
	localparam int Z_LO = -(2 ** (Z_W - 1));
	localparam logic [THR_W-1:0] LIMIT_MAX = '1;

	localparam int DRAIN_CYCLES  = 30;
	localparam int LONG_HOLD     = 400;
	localparam int STALL_LIMIT   = 20000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 100;

	// keeps the running group totals and the verdicts still owed by the block
	class verdict_book;
		bit filter_on;
		logic [THR_W-1:0] var_limit;
		logic [CNT_W-1:0] n_seen;
		logic signed [SUM_W-1:0] z_total;
		logic [SQS_W-1:0] z2_total;
		bit too_many;
		svtf_out_t due[$];
		int failures;
		int samples;
		int groups;
		int kept;
		int dropped;
		int overflowed;
		int longest;
		int run_len;

		function void clear_totals();
			n_seen = '0;
			z_total = '0;
			z2_total = '0;
			too_many = 1'b0;
			run_len = 0;
		endfunction

		function new();
			filter_on = 1'b0;
			var_limit = '0;
			failures = 0;
			samples = 0;
			groups = 0;
			kept = 0;
			dropped = 0;
			overflowed = 0;
			longest = 0;
			clear_totals();
		endfunction

		function void set_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
			if (addr == ADDR_ENABLE)
				filter_on = value[0];
			else if (addr == ADDR_LIMIT)
				var_limit = value[THR_W-1:0];
		endfunction

		// exact test n*S2 - S1^2 < limit*n*(n-1) in 128 bits
		function bit spread_below_limit();
			logic signed [127:0] sum_wide;
			logic [127:0] n;
			logic [127:0] sq_total;
			logic [127:0] sum_mag;
			logic [127:0] lhs;
			logic [127:0] rhs;
			logic [127:0] limit_wide;
			sum_wide = z_total;
			sum_mag = (sum_wide < 0) ? -sum_wide : sum_wide;
			n = n_seen;
			sq_total = z2_total;
			limit_wide = var_limit;
			lhs = n * sq_total - sum_mag * sum_mag;
			rhs = n * (n - 1);
			rhs = rhs * limit_wide;
			return lhs < rhs;
		endfunction

		function void note_sample(svtf_in_t beat);
			logic signed [Z_W-1:0] z;
			logic signed [SUM_W-1:0] z_wide;
			logic signed [SQ_W-1:0] z_ext;
			logic [SQ_W-1:0] z_sq;
			svtf_out_t want;
			z = beat.z_sample;
			z_wide = z;
			z_ext = z;
			samples++;
			run_len++;
			// samples past the bound are not summed, only flagged
			if (n_seen < MAX_SAMPLES) begin
				n_seen = n_seen + 1'b1;
				z_total = z_total + z_wide;
				z_sq = z_ext * z_ext;
				z2_total = z2_total + z_sq;
			end else
				too_many = 1'b1;
			if (!beat.last_sample)
				return;
			want.count_overflow = too_many;
			if (too_many)
				want.keep_group = 1'b0;
			else if (!filter_on || n_seen <= 1)
				want.keep_group = 1'b1;
			else
				want.keep_group = spread_below_limit();
			due.push_back(want);
			groups++;
			if (too_many)
				overflowed++;
			else if (want.keep_group)
				kept++;
			else
				dropped++;
			if (run_len > longest)
				longest = run_len;
			clear_totals();
		endfunction

		function void check_verdict(svtf_out_t got);
			svtf_out_t want;
			if (due.size() == 0) begin
				$error("verdict with no group pending: keep_group %0b count_overflow %0b",
					got.keep_group, got.count_overflow);
				failures++;
				return;
			end
			want = due.pop_front();
			if (got.keep_group !== want.keep_group) begin
				$error("keep_group: expected %0b, got %0b", want.keep_group, got.keep_group);
				failures++;
			end
			if (got.count_overflow !== want.count_overflow) begin
				$error("count_overflow: expected %0b, got %0b",
					want.count_overflow, got.count_overflow);
				failures++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	svtf_in_t in_data;
	logic out_valid;
	logic out_ready;
	svtf_out_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	verdict_book book;
	bit hold_pending = 1'b0;
	int settings = 0;

	sample_variance_threshold_filter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one sample beat, with an optional idle stretch in front of it
	task automatic send_sample(input logic signed [Z_W-1:0] z, input bit last, input bit calm);
		svtf_in_t beat;
		if (!calm && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
		beat.z_sample = z;
		beat.last_sample = last;
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (!in_ready);
		book.note_sample(beat);
	endtask

	// long group at full rate: flat at the minimum or alternating extremes
	task automatic send_run(input int count, input bit alternate);
		int i;
		for (i = 0; i < count; i++)
			send_sample((alternate && i[0]) ? Z_MAX : Z_MIN, i == count - 1, 1'b1);
	endtask

	// group of random heights around a random center
	task automatic send_random_group(input int count);
		int center;
		int spread;
		int v;
		int i;
		bit wild;
		bit calm;
		center = int'($urandom_range(0, 2 * Z_HI + 1)) + Z_LO;
		spread = $urandom_range(0, 1 << $urandom_range(0, Z_W - 1));
		wild = ($urandom_range(0, 9) == 0);
		calm = ($urandom_range(0, 3) == 0);
		for (i = 0; i < count; i++) begin
			if (wild)
				v = int'($urandom_range(0, 2 * Z_HI + 1)) + Z_LO;
			else
				v = center + int'($urandom_range(0, 2 * spread)) - spread;
			if (v > Z_HI)
				v = Z_HI;
			if (v < Z_LO)
				v = Z_LO;
			send_sample(Z_W'(v), i == count - 1, calm);
		end
	endtask

	function automatic int group_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 1;
		if (r < 30)
			return 2;
		if (r < 75)
			return $urandom_range(3, 12);
		if (r < 95)
			return $urandom_range(13, 40);
		return $urandom_range(41, 150);
	endfunction

	// stop offering and wait for every owed verdict plus the back end latency
	task automatic settle();
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		book.set_reg(addr, value);
	endtask

	// both registers, optionally with junk above the used bits
	task automatic configure(input bit enable, input logic [THR_W-1:0] limit, input bit noisy);
		logic [APB_DATA_W-1:0] junk;
		settle();
		junk = noisy ? {$urandom(), $urandom()} : '0;
		write_reg(ADDR_ENABLE, {junk[APB_DATA_W-1:1], enable});
		write_reg(ADDR_LIMIT, {junk[APB_DATA_W-1:THR_W], limit});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		settings++;
	endtask

	// result side: random stalls, calm stretches, one long hold on request
	initial begin : result_sink
		int stall_left;
		int mode_left;
		bit calm;
		stall_left = 0;
		mode_left = 0;
		calm = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				book.check_verdict(out_data);
			if (hold_pending) begin
				hold_pending = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(50, 300);
			end else
				mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				stall_left = idle_len() - 1;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	// give up after a long stretch with no beat and no register write
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("sample_variance_threshold_filter_top_test failed");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int phase_items;
		int size;
		bit enable;
		logic [THR_W-1:0] limit;
		book = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: filter off keeps everything
		send_sample(Z_MAX, 1'b0, 1'b1);
		send_sample(Z_MIN, 1'b0, 1'b1);
		send_sample(Z_W'(0), 1'b1, 1'b1);
		send_sample(Z_MIN, 1'b1, 1'b1);

		// zero threshold drops even a flat pair, single sample still kept
		configure(1'b1, '0, 1'b0);
		send_sample(Z_W'(5), 1'b0, 1'b1);
		send_sample(Z_W'(5), 1'b1, 1'b1);
		send_sample(Z_MAX, 1'b1, 1'b1);

		// small threshold around exact ties
		configure(1'b1, THR_W'(2), 1'b0);
		send_sample(Z_W'(0), 1'b0, 1'b1);
		send_sample(Z_W'(2), 1'b1, 1'b1);
		send_sample(Z_W'(0), 1'b0, 1'b1);
		send_sample(Z_W'(1), 1'b1, 1'b1);
		send_sample(Z_W'(-1), 1'b0, 1'b1);
		send_sample(Z_W'(1), 1'b1, 1'b1);

		// largest threshold: extremes swing drops, flat group kept
		configure(1'b1, LIMIT_MAX, 1'b0);
		send_sample(Z_MAX, 1'b0, 1'b0);
		send_sample(Z_MIN, 1'b0, 1'b0);
		send_sample(Z_MAX, 1'b0, 1'b0);
		send_sample(Z_MIN, 1'b1, 1'b0);
		send_sample(Z_MIN, 1'b0, 1'b0);
		send_sample(Z_MIN, 1'b0, 1'b0);
		send_sample(Z_MIN, 1'b1, 1'b0);

		// long groups at full rate, flat and swinging between extremes, filter on and off
		configure(1'b1, THR_W'(1), 1'b0);
		send_run(64, 1'b0);
		send_run(65, 1'b1);
		configure(1'b0, '0, 1'b0);
		send_run(67, 1'b0);

		// random groups under a spread of settings
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			enable = 1'b1;
			case (phase)
				0: limit = THR_W'($urandom_range(0, 65535));
				1: limit = LIMIT_MAX;
				2: begin
					enable = 1'b0;
					limit = THR_W'({$urandom(), $urandom()});
				end
				3: limit = '0;
				4: limit = THR_W'({$urandom(), $urandom()});
				default: limit = THR_W'($urandom_range(0, 4095));
			endcase
			configure(enable, limit, phase[0]);
			// results held back a long time while samples keep coming
			if (phase == 0)
				hold_pending = 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				size = group_size();
				send_random_group(size);
				phase_items += size;
			end
		end
		settle();

		$display("covered %0d groups, %0d samples, %0d register settings, longest group %0d",
			book.groups, book.samples, settings, book.longest);
		$display("verdicts: %0d kept, %0d dropped as uneven, %0d over the sample bound",
			book.kept, book.dropped, book.overflowed);
		if (book.failures == 0)
			$display("sample_variance_threshold_filter_top_test passed");
		else
			$display("sample_variance_threshold_filter_top_test failed");
		$finish;
	end

endmodule
